@@ hw/rtl/arm_data_processing_shifted_register_top_assert.svh @@
// assertion macros for the data-processing unit
`ifndef ARM_DATA_PROCESSING_SHIFTED_REGISTER_TOP_ASSERT_SVH
`define ARM_DATA_PROCESSING_SHIFTED_REGISTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADPSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ADPSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/adpsr_pkg.sv @@
// shared types, opcodes and constants of the data-processing unit
package adpsr_pkg;

   localparam int unsigned WordBits = 32;
   localparam int unsigned RegCount = 15;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [3:0]          reg_idx_type;
   typedef logic [3:0]          nzcv_type;

   // pc reads see the instruction address plus this offset
   localparam word_type PC_AHEAD = 32'd8;
   localparam reg_idx_type PC_IDX = 4'd15;

   // commands
   localparam logic [1:0] CMD_EXEC       = 2'd0;
   localparam logic [1:0] CMD_LOAD_REG   = 2'd1;
   localparam logic [1:0] CMD_LOAD_FLAGS = 2'd2;

   // opcodes in architectural order
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   // shift kinds, codes above ror act as rrx
   localparam logic [2:0] SH_LSL = 3'd0;
   localparam logic [2:0] SH_LSR = 3'd1;
   localparam logic [2:0] SH_ASR = 3'd2;
   localparam logic [2:0] SH_ROR = 3'd3;
   localparam logic [2:0] SH_RRX = 3'd4;

   // flag bit positions
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   // alu side information
   typedef struct packed {
      logic carry;
      logic overflow;
      logic is_test;
   } alu_status_type;

endpackage

@@ hw/rtl/adpsr_if.sv @@
// request and response channel interfaces
interface adpsr_req_if;
   import adpsr_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  alu_op;
   logic [2:0]  shift_kind;
   logic [5:0]  shift_amount;
   logic        update_flags;
   reg_idx_type dest_reg;
   reg_idx_type first_reg;
   reg_idx_type shifted_reg;
   word_type    insn_address;
   word_type    load_value;

   modport source (output valid, command, alu_op, shift_kind, shift_amount, update_flags,
                   dest_reg, first_reg, shifted_reg, insn_address, load_value,
                   input ready);
   modport sink (input valid, command, alu_op, shift_kind, shift_amount, update_flags,
                 dest_reg, first_reg, shifted_reg, insn_address, load_value,
                 output ready);
endinterface

interface adpsr_rsp_if;
   import adpsr_pkg::*;
   logic     valid;
   logic     ready;
   word_type result_value;
   nzcv_type flags_out;
   logic     branch_taken;
   logic     reg_written;

   modport source (output valid, result_value, flags_out, branch_taken, reg_written,
                   input ready);
   modport sink (input valid, result_value, flags_out, branch_taken, reg_written,
                 output ready);
endinterface

@@ hw/rtl/adpsr_alu.sv @@
// barrel shifter and alu for one data-processing instruction
module adpsr_alu (
   input  adpsr_pkg::word_type       rn,
   input  adpsr_pkg::word_type       rm,
   input  logic [3:0]                alu_op,
   input  logic [2:0]                shift_kind,
   input  logic [5:0]                shift_amount,
   input  adpsr_pkg::nzcv_type       flags,
   output adpsr_pkg::word_type       result,
   output adpsr_pkg::alu_status_type status
);
   import adpsr_pkg::*;

   logic               cin;
   logic [WordBits:0]  lsl_tmp;
   logic [WordBits:0]  lsr_tmp;
   logic signed [WordBits:0] asr_tmp;
   logic [2*WordBits-1:0] ror_tmp;
   word_type           sh_val;
   logic               sh_carry;
   word_type           add_x;
   word_type           add_y;
   logic               add_c;
   logic [WordBits:0]  sum;
   logic               uses_adder;

   assign cin = flags[FLAG_C];

   // shifter: extra bit on the shifted-out side gives the carry
   always_comb begin
      lsl_tmp  = {1'b0, rm} << shift_amount;
      lsr_tmp  = {rm, 1'b0} >> shift_amount;
      asr_tmp  = $signed({rm, 1'b0}) >>> shift_amount;
      ror_tmp  = {rm, rm} >> shift_amount[4:0];
      sh_val   = rm;
      sh_carry = cin;
      case (shift_kind)
         SH_LSL: begin
            if (shift_amount != 6'd0) begin
               sh_val   = lsl_tmp[WordBits-1:0];
               sh_carry = lsl_tmp[WordBits];
            end
         end
         SH_LSR: begin
            if (shift_amount != 6'd0) begin
               sh_val   = lsr_tmp[WordBits:1];
               sh_carry = lsr_tmp[0];
            end
         end
         SH_ASR: begin
            if (shift_amount != 6'd0) begin
               sh_val   = asr_tmp[WordBits:1];
               sh_carry = asr_tmp[0];
            end
         end
         SH_ROR: begin
            if (shift_amount != 6'd0) begin
               sh_val   = ror_tmp[WordBits-1:0];
               sh_carry = ror_tmp[WordBits-1];
            end
         end
         default: begin
            // rrx
            sh_val   = {cin, rm[WordBits-1:1]};
            sh_carry = rm[0];
         end
      endcase
   end

   // adder operand selection
   always_comb begin
      add_x      = rn;
      add_y      = sh_val;
      add_c      = 1'b0;
      uses_adder = 1'b1;
      case (alu_op)
         OP_SUB, OP_CMP: begin
            add_y = ~sh_val;
            add_c = 1'b1;
         end
         OP_RSB: begin
            add_x = sh_val;
            add_y = ~rn;
            add_c = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_c = 1'b0;
         end
         OP_ADC: begin
            add_c = cin;
         end
         OP_SBC: begin
            add_y = ~sh_val;
            add_c = cin;
         end
         OP_RSC: begin
            add_x = sh_val;
            add_y = ~rn;
            add_c = cin;
         end
         default: begin
            uses_adder = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {{WordBits{1'b0}}, add_c};

   // result selection
   always_comb begin
      case (alu_op)
         OP_AND, OP_TST: result = rn & sh_val;
         OP_EOR, OP_TEQ: result = rn ^ sh_val;
         OP_ORR:         result = rn | sh_val;
         OP_MOV:         result = sh_val;
         OP_BIC:         result = rn & ~sh_val;
         OP_MVN:         result = ~sh_val;
         default:        result = sum[WordBits-1:0];
      endcase
   end

   // carry and overflow: adder for arithmetic ops, shifter and old v otherwise
   always_comb begin
      status.is_test  = (alu_op == OP_TST) || (alu_op == OP_TEQ) ||
                        (alu_op == OP_CMP) || (alu_op == OP_CMN);
      if (uses_adder) begin
         status.carry    = sum[WordBits];
         status.overflow = (add_x[WordBits-1] ^ sum[WordBits-1]) &
                           (add_y[WordBits-1] ^ sum[WordBits-1]);
      end else begin
         status.carry    = sh_carry;
         status.overflow = flags[FLAG_V];
      end
   end

endmodule

@@ hw/rtl/arm_data_processing_shifted_register_top.sv @@
// Data-processing unit for ARM instructions with an immediate-shifted register operand.
// One item per cycle sustained while responses are taken; an accepted item passes through the
// execute stage register into the response register. The fifteen general registers live in a
// synchronous memory with two read ports
// and one write port: Rn and Rm are read at the edge that accepts an item, the shifter and
// ALU work in the following cycle, and the write back to the memory and the flag update
// happen at the edge that loads the response register. A write in that same edge is
// forwarded into the read data of the item then being accepted. Per-register valid bits
// make never-written registers read as zero after reset, so no clearing pass is needed.
// Reads of R15 return the instruction address plus 8. The response register decouples
// the two channels; a stalled response holds the one item in the execute stage.
module arm_data_processing_shifted_register_top (
   input logic    clock,
   input logic    reset,
   adpsr_req_if.sink   req_chan,
   adpsr_rsp_if.source rsp_chan
);
   import adpsr_pkg::*;

`include "arm_data_processing_shifted_register_top_assert.svh"

   // register file storage
   word_type mem [RegCount];
   logic [RegCount-1:0] reg_vld_ff;

   // handshake
   logic accept;
   logic out_free;
   logic s1_adv;
   logic s1_vld_ff;
   logic rsp_vld_ff;

   // execute stage payload
   logic [1:0]  s1_cmd_ff;
   logic [3:0]  s1_op_ff;
   logic [2:0]  s1_kind_ff;
   logic [5:0]  s1_amt_ff;
   logic        s1_s_ff;
   reg_idx_type s1_rd_ff;
   logic        s1_rn_pc_ff;
   logic        s1_rm_pc_ff;
   word_type    s1_addr_ff;
   word_type    s1_load_ff;

   // read data and forwarding
   word_type rn_raw_ff;
   word_type rm_raw_ff;
   logic     rn_vld_ff;
   logic     rm_vld_ff;
   logic     rn_fwd_ff;
   logic     rm_fwd_ff;
   word_type fwd_data_ff;

   // execute stage logic
   word_type       pc_val;
   word_type       rn_val;
   word_type       rm_val;
   word_type       alu_res;
   alu_status_type alu_stat;
   logic           is_exec;
   logic           is_branch;
   logic           wr_en;
   reg_idx_type    wr_addr;
   word_type       wr_data;
   nzcv_type       nzcv_ff;
   nzcv_type       nzcv_in;
   word_type       result_in;

   // response register
   word_type rsp_result_ff;
   nzcv_type rsp_flags_ff;
   logic     rsp_branch_ff;
   logic     rsp_wrote_ff;

   // flow control
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;
   assign s1_adv         = s1_vld_ff && out_free;
   assign req_chan.ready = !s1_vld_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   // operand values with pc substitution, forwarding and never-written zero
   assign pc_val = s1_addr_ff + PC_AHEAD;
   always_comb begin
      if (s1_rn_pc_ff) rn_val = pc_val;
      else if (rn_fwd_ff) rn_val = fwd_data_ff;
      else if (rn_vld_ff) rn_val = rn_raw_ff;
      else rn_val = '0;
      if (s1_rm_pc_ff) rm_val = pc_val;
      else if (rm_fwd_ff) rm_val = fwd_data_ff;
      else if (rm_vld_ff) rm_val = rm_raw_ff;
      else rm_val = '0;
   end

   adpsr_alu u_alu (
      .rn           (rn_val),
      .rm           (rm_val),
      .alu_op       (s1_op_ff),
      .shift_kind   (s1_kind_ff),
      .shift_amount (s1_amt_ff),
      .flags        (nzcv_ff),
      .result       (alu_res),
      .status       (alu_stat)
   );

   // write back, flags and result value
   assign is_exec   = (s1_cmd_ff == CMD_EXEC);
   assign is_branch = is_exec && !alu_stat.is_test && (s1_rd_ff == PC_IDX);
   assign wr_addr   = s1_rd_ff;
   assign wr_data   = (s1_cmd_ff == CMD_LOAD_REG) ? s1_load_ff : alu_res;
   assign wr_en     = s1_adv && (s1_rd_ff != PC_IDX) &&
                      ((s1_cmd_ff == CMD_LOAD_REG) || (is_exec && !alu_stat.is_test));

   always_comb begin
      nzcv_in = nzcv_ff;
      if (s1_cmd_ff == CMD_LOAD_FLAGS) begin
         nzcv_in = s1_load_ff[3:0];
      end else if (is_exec && !is_branch && s1_s_ff) begin
         nzcv_in = {alu_res[WordBits-1], (alu_res == '0), alu_stat.carry, alu_stat.overflow};
      end
   end

   always_comb begin
      case (s1_cmd_ff)
         CMD_EXEC:     result_in = alu_res;
         CMD_LOAD_REG: result_in = s1_load_ff;
         default:      result_in = '0;
      endcase
   end

   // register file memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rn_raw_ff <= mem[req_chan.first_reg];
         rm_raw_ff <= mem[req_chan.shifted_reg];
      end
   end

   // valid bits and forwarding selects captured with the read
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
         rn_vld_ff  <= 1'b0;
         rm_vld_ff  <= 1'b0;
         rn_fwd_ff  <= 1'b0;
         rm_fwd_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            reg_vld_ff[wr_addr] <= 1'b1;
         end
         if (accept) begin
            rn_vld_ff <= (req_chan.first_reg != PC_IDX) && reg_vld_ff[req_chan.first_reg];
            rm_vld_ff <= (req_chan.shifted_reg != PC_IDX) && reg_vld_ff[req_chan.shifted_reg];
            rn_fwd_ff <= wr_en && (wr_addr == req_chan.first_reg);
            rm_fwd_ff <= wr_en && (wr_addr == req_chan.shifted_reg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= wr_data;
      end
   end

   // execute stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req_chan.command;
         s1_op_ff    <= req_chan.alu_op;
         s1_kind_ff  <= req_chan.shift_kind;
         s1_amt_ff   <= req_chan.shift_amount;
         s1_s_ff     <= req_chan.update_flags;
         s1_rd_ff    <= req_chan.dest_reg;
         s1_rn_pc_ff <= (req_chan.first_reg == PC_IDX);
         s1_rm_pc_ff <= (req_chan.shifted_reg == PC_IDX);
         s1_addr_ff  <= req_chan.insn_address;
         s1_load_ff  <= req_chan.load_value;
      end
   end

   // stage valids and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         nzcv_ff    <= '0;
      end else begin
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_vld_ff <= 1'b1;
            nzcv_ff    <= nzcv_in;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_result_ff <= result_in;
         rsp_flags_ff  <= nzcv_in;
         rsp_branch_ff <= is_branch;
         rsp_wrote_ff  <= wr_en;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.result_value = rsp_result_ff;
   assign rsp_chan.flags_out    = rsp_flags_ff;
   assign rsp_chan.branch_taken = rsp_branch_ff;
   assign rsp_chan.reg_written  = rsp_wrote_ff;

   // checks
   `ADPSR_ASSERT_NOW(a_branch_no_write, clock, reset, rsp_vld_ff,
      !(rsp_branch_ff && rsp_wrote_ff), "branch and register write in one response")
   `ADPSR_ASSERT_NEXT(a_write_reported, clock, reset, wr_en,
      rsp_vld_ff && rsp_wrote_ff, "register write not reported in response")
   `ADPSR_ASSERT_NEXT(a_flags_hold, clock, reset, !s1_adv,
      $stable(nzcv_ff), "flags changed without a retiring item")
   `ADPSR_ASSERT_NEXT(a_stage_holds, clock, reset, s1_vld_ff && !out_free,
      s1_vld_ff && $stable(s1_rd_ff), "stalled execute stage lost its item")

endmodule
